>>> hdl/skhs_pkg.sv
package skhs_pkg;

    localparam int unsigned MOD_W = 28;
    localparam int unsigned MAG_W = 35;
    localparam int unsigned HASH_W = 32;

    localparam logic [MOD_W-1:0] POLY_MOD = 28'd167772161;
    localparam logic [MOD_W-1:0] POLY_ONE = 28'd1;
    localparam logic signed [8:0] LETTER_A = 9'sd65;
    localparam logic [HASH_W-1:0] DJB_START = 32'd5381;
    localparam int unsigned ROT_AMT = 13;

    // POLY_MOD = 5 * 2^25 + 1; quotient estimate is (mag >> 25) / 5
    localparam int unsigned QSHIFT = 25;
    localparam int unsigned QTOP_W = MAG_W - QSHIFT;
    localparam logic [17:0] RECIP_5 = 18'd205;

    typedef enum logic [1:0] {
        SEL_POLY = 2'd0,
        SEL_ROT  = 2'd1,
        SEL_DJB  = 2'd2
    } hash_sel_t;

endpackage

>>> hdl/string_key_hash_select.sv
// string_key_hash_select
// Hashes a key delivered one byte per beat on the input channel
// (in_valid/in_ready, key_byte, last_byte). The beat with last_byte set
// closes the key; one 32-bit hash_value beat then appears on the output
// channel (out_valid/out_ready). Bytes without last_byte give no output.
// cfg_wr_en/cfg_wr_data write hash_select (0 polynomial mod 167772161,
// 1 rotating, 2 or 3 djb2) and restart the running hash; write it only
// with the pipe empty.
// Throughput: one byte per cycle while no last byte waits on a full output
// register. The power register (times 72 mod M) and the accumulator are the
// only loops. A last byte passes the input, magnitude and term registers,
// then the accumulator writes its hash into the output register, which
// drives hash_value.
// Reset: select back to polynomial, running hash to its start value,
// pipe and output emptied.
// Output stall: the output register holds its beat; bytes keep flowing
// through the pipe and only a last byte waits in front of a full output
// register, backing up the pipe one stage at a time.
module string_key_hash_select (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  key_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data
);
    import skhs_pkg::*;

    logic [1:0]        sel_reg;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [MOD_W-1:0]  pm_reg, pm_next;

    logic              v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic [7:0]        b1_reg, b2_reg, b3_reg;
    logic              l1_reg, l2_reg, l3_reg;
    logic [MOD_W-1:0]  p1_reg;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg2_reg, neg_next;
    logic signed [MOD_W:0] term_reg, term_next;
    logic [HASH_W-1:0] out_reg;

    logic in_fire, adv1, adv2, adv3, out_free;

    logic [MAG_W-1:0]  pm_x72;
    logic [MOD_W-1:0]  pm_red;
    logic [MOD_W-1:0]  term_rem;
    logic signed [8:0] dval;
    logic [7:0]        dmag;

    logic signed [MOD_W+1:0] acc_sum, acc_fix;
    logic signed [MOD_W+1:0] mod_s;
    logic [HASH_W-1:0] rot_h, hash_upd, start_val;

    // handshake through the pipe
    assign out_free = !out_valid_reg || out_ready;
    assign adv3     = v3_reg && (!l3_reg || out_free);
    assign adv2     = v2_reg && (!v3_reg || adv3);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign in_ready = !v1_reg || adv1;
    assign in_fire  = in_valid && in_ready;

    // power update: pm * 72 mod M
    assign pm_x72 = ({{(MAG_W-MOD_W){1'b0}}, pm_reg} << 6)
                  + ({{(MAG_W-MOD_W){1'b0}}, pm_reg} << 3);

    skhs_mod_reduce u_pm_reduce (
        .mag (pm_x72),
        .rem (pm_red)
    );

    assign start_val = (sel_reg >= SEL_DJB) ? DJB_START : '0;

    always_comb
    begin
        if (in_fire && last_byte)
        begin
            pm_next = POLY_ONE;
        end
        else if (in_fire)
        begin
            pm_next = pm_red;
        end
        else
        begin
            pm_next = pm_reg;
        end
    end

    // stage 1: |byte - 'A'| * power
    assign dval     = $signed({b1_reg[7], b1_reg}) - LETTER_A;
    assign neg_next = dval[8];
    assign dmag     = neg_next ? 8'(-dval) : dval[7:0];
    assign mag_next = {{(MAG_W-8){1'b0}}, dmag} * {{(MAG_W-MOD_W){1'b0}}, p1_reg};

    // stage 2: truncated remainder, sign restored
    skhs_mod_reduce u_term_reduce (
        .mag (mag_reg),
        .rem (term_rem)
    );

    assign term_next = neg2_reg ? -$signed({1'b0, term_rem}) : $signed({1'b0, term_rem});

    // stage 3: accumulate
    assign mod_s   = $signed({2'b00, POLY_MOD});
    assign acc_sum = $signed({hash_reg[MOD_W], hash_reg[MOD_W:0]})
                   + $signed({term_reg[MOD_W], term_reg});
    assign rot_h   = hash_reg + {24'b0, b3_reg};

    always_comb
    begin
        if (acc_sum >= mod_s)
        begin
            acc_fix = acc_sum - mod_s;
        end
        else if (acc_sum <= -mod_s)
        begin
            acc_fix = acc_sum + mod_s;
        end
        else
        begin
            acc_fix = acc_sum;
        end
    end

    always_comb
    begin
        unique case (sel_reg)
            SEL_POLY:
            begin
                hash_upd = {{(HASH_W-MOD_W-2){acc_fix[MOD_W+1]}}, acc_fix};
            end
            SEL_ROT:
            begin
                hash_upd = rot_h - {rot_h[HASH_W-ROT_AMT-1:0], rot_h[HASH_W-1:HASH_W-ROT_AMT]};
            end
            default:
            begin
                hash_upd = (hash_reg << 5) + hash_reg + {{24{b3_reg[7]}}, b3_reg};
            end
        endcase
    end

    always_comb
    begin
        if (adv3 && l3_reg)
        begin
            hash_next = start_val;
        end
        else if (adv3)
        begin
            hash_next = hash_upd;
        end
        else
        begin
            hash_next = hash_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= SEL_POLY;
            hash_reg      <= '0;
            pm_reg        <= POLY_ONE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sel_reg  <= cfg_wr_data;
                hash_reg <= (cfg_wr_data >= SEL_DJB) ? DJB_START : '0;
                pm_reg   <= POLY_ONE;
            end
            else
            begin
                hash_reg <= hash_next;
                pm_reg   <= pm_next;
            end
            v1_reg        <= in_fire || (v1_reg && !adv1);
            v2_reg        <= adv1 || (v2_reg && !adv2);
            v3_reg        <= adv2 || (v3_reg && !adv3);
            out_valid_reg <= (adv3 && l3_reg) || (out_valid_reg && !out_ready);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b1_reg <= key_byte;
            l1_reg <= last_byte;
            p1_reg <= pm_reg;
        end
        if (adv1)
        begin
            b2_reg   <= b1_reg;
            l2_reg   <= l1_reg;
            mag_reg  <= mag_next;
            neg2_reg <= neg_next;
        end
        if (adv2)
        begin
            b3_reg   <= b2_reg;
            l3_reg   <= l2_reg;
            term_reg <= term_next;
        end
        if (adv3 && l3_reg)
        begin
            out_reg <= hash_upd;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

`ifndef SYNTHESIS
    a_pm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pm_reg != '0) && (pm_reg < POLY_MOD))
        else $error("power register out of range");

    a_poly_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg == SEL_POLY) |->
        ($signed(hash_reg) < $signed({4'b0, POLY_MOD}))
        && ($signed(hash_reg) > -$signed({4'b0, POLY_MOD})))
        else $error("polynomial accumulator out of range");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (term_rem < POLY_MOD))
        else $error("term remainder not reduced");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(adv3 && l3_reg))
        else $error("output beat without a last byte");
`endif

endmodule

>>> hdl/skhs_mod_reduce.sv
module skhs_mod_reduce (
    input  logic [skhs_pkg::MAG_W-1:0] mag,
    output logic [skhs_pkg::MOD_W-1:0] rem
);
    import skhs_pkg::*;

    logic [QTOP_W-1:0] top;
    logic [17:0]       q_scaled;
    logic [7:0]        q_est;
    logic [MAG_W-1:0]  q_mod;
    logic [MAG_W:0]    diff;
    logic [MAG_W:0]    fixed;

    // q_est is the true quotient or one above it
    assign top      = mag[MAG_W-1:QSHIFT];
    assign q_scaled = {{(18-QTOP_W){1'b0}}, top} * RECIP_5;
    assign q_est    = q_scaled[17:10];
    assign q_mod    = {{(MAG_W-8){1'b0}}, q_est} * {{(MAG_W-MOD_W){1'b0}}, POLY_MOD};
    assign diff     = {1'b0, mag} - {1'b0, q_mod};
    assign fixed    = diff[MAG_W] ? (diff + {{(MAG_W+1-MOD_W){1'b0}}, POLY_MOD}) : diff;
    assign rem      = fixed[MOD_W-1:0];

endmodule

>>> dv/tb_string_key_hash_select.sv
module tb_string_key_hash_select;

    import skhs_pkg::*;

    localparam logic [1:0]  SEL_DJB_ALT = 2'd3;
    localparam longint      MOD_M       = 167772161;
    localparam longint      BASE_X      = 72;
    localparam longint      CHAR_A      = 65;
    localparam logic [31:0] DJB_SEED    = 32'd5381;
    localparam int          DRAIN_CYC   = 8;
    localparam int          STALL_LIMIT = 2000;
    localparam int          N_ROWS      = 30;
    localparam int          N_PHASES    = 10;
    localparam int          PHASE_BYTES = 100;

    typedef enum logic {ROW_SEL, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        logic [31:0] want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  key_byte    = 8'h00;
    logic        last_byte   = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] hash_value;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = SEL_POLY;

    logic [1:0]  model_sel;
    logic [31:0] model_hash;
    logic [27:0] model_pow;

    logic [31:0] pending_hashes[$];
    logic [31:0] oldest_hash;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          sink_left      = 0;
    int          sink_pick;
    logic        quiet_sender   = 1'b0;

    // select 3 and a mid-key select write are in here on purpose
    stim_row_t dir_rows [N_ROWS] = '{
        '{ROW_BYTE, 8'h41, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_BYTE, 8'h42, 1'b1, 1'b1, 32'h0000_0001},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFBF},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFBE},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b1, 32'hFFFF_FF3F},
        '{ROW_BYTE, 8'h7F, 1'b1, 1'b1, 32'h0000_003E},
        '{ROW_BYTE, 8'h41, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h42, 1'b1, 1'b1, 32'h0000_0048},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h41, 1'b1, 1'b1, 32'hFFFF_FFBF},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b0, 32'h0},
        '{ROW_SEL,  {6'd0, SEL_ROT}, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b1, 32'hFFFF_E001},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 32'h0},
        '{ROW_SEL,  {6'd0, SEL_DJB}, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0002_B5A5},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 32'h0002_B5A4},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b1, 32'h0002_B525},
        '{ROW_BYTE, 8'h7F, 1'b1, 1'b1, 32'h0002_B624},
        '{ROW_SEL,  {6'd0, SEL_DJB_ALT}, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 32'h0002_B5A5},
        '{ROW_BYTE, 8'h41, 1'b0, 1'b0, 32'h0},
        '{ROW_SEL,  {6'd0, SEL_POLY}, 1'b0, 1'b0, 32'h0},
        '{ROW_BYTE, 8'h42, 1'b1, 1'b1, 32'h0000_0001}
    };

    string_key_hash_select i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_byte    (key_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_model();
        model_hash = (model_sel == SEL_POLY || model_sel == SEL_ROT) ? 32'd0 : DJB_SEED;
        model_pow  = 28'd1;
    endfunction

    function automatic void fold_byte(input logic [7:0] b, input logic fin,
                                      output logic done, output logic [31:0] h);
        longint acc;
        longint term;
        longint pw_next;
        logic [31:0] t;
        if (model_sel == SEL_POLY)
        begin
            acc        = longint'($signed(model_hash));
            term       = (longint'($signed(b)) - CHAR_A) * longint'(model_pow);
            acc        = (acc + term % MOD_M) % MOD_M;
            model_hash = acc[31:0];
            pw_next    = (longint'(model_pow) * BASE_X) % MOD_M;
            model_pow  = pw_next[27:0];
        end
        else if (model_sel == SEL_ROT)
        begin
            t          = model_hash + {24'd0, b};
            model_hash = t - {t[18:0], t[31:19]};
        end
        else
        begin
            model_hash = model_hash * 32'd33 + {{24{b[7]}}, b};
        end
        done = fin;
        h    = model_hash;
        if (fin)
            restart_model();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 20)
            $display("ERROR @%0t %s: got %08h want %08h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 24);
        else
            return $urandom_range(25, 64);
    endfunction

    // called right after an accepting edge, or with in_valid already low
    task automatic push_byte(input logic [7:0] b, input logic fin,
                             input logic typed, input logic [31:0] want);
        int gap;
        logic done;
        logic [31:0] h;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_byte  <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_byte(b, fin, done, h);
        if (done)
            pending_hashes.push_back(typed ? want : h);
    endtask

    task automatic settle_pipe();
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_select(input logic [1:0] sel);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_sel = sel;
        restart_model();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
                report_mismatch("hash beat with none expected", hash_value, 32'h0);
            else
            begin
                oldest_hash = pending_hashes.pop_front();
                if (hash_value !== oldest_hash)
                    report_mismatch("hash_value", hash_value, oldest_hash);
            end
        end
    end

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 50)
            begin
                out_ready <= 1'b1;
                sink_left <= $urandom_range(1, 20);
            end
            else if (sink_pick < 60)
            begin
                out_ready <= 1'b1;
                sink_left <= $urandom_range(40, 120);
            end
            else if (sink_pick < 90)
            begin
                out_ready <= 1'b0;
                sink_left <= $urandom_range(0, 2);
            end
            else if (sink_pick < 98)
            begin
                out_ready <= 1'b0;
                sink_left <= $urandom_range(3, 19);
            end
            else
            begin
                out_ready <= 1'b0;
                sink_left <= $urandom_range(30, 80);
            end
        end
        else
            sink_left <= sink_left - 1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR @%0t no beat moved for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [1:0] sel;
        int n;
        int klen;
        model_sel = SEL_POLY;
        restart_model();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SEL)
            begin
                settle_pipe();
                write_select(dir_rows[i].data[1:0]);
            end
            else
                push_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                          dir_rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle_pipe();
            sel = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
            write_select(sel);
            quiet_sender = (ph % 4 == 1);
            n = 0;
            while (n < PHASE_BYTES)
            begin
                klen = pick_len();
                for (int k = 0; k < klen; k++)
                    push_byte(pick_byte(), k == klen - 1, 1'b0, 32'h0);
                n += klen;
            end
            // partial key, dropped by the next select write if another phase follows
            if ($urandom_range(0, 2) == 0)
            begin
                klen = $urandom_range(1, 5);
                for (int k = 0; k < klen; k++)
                    push_byte(pick_byte(), 1'b0, 1'b0, 32'h0);
            end
        end

        settle_pipe();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
